// ===== rtl/delta_timer_queue_assert.svh =====
// Assertion macros shared by the delta timer queue RTL.
`ifndef DELTA_TIMER_QUEUE_ASSERT_SVH
`define DELTA_TIMER_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dtq_pkg.sv =====
// Types, constants and controller/datapath interface of the delta timer queue.
package dtq_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W      = $clog2(TIMER_SLOTS);
	localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

	// Port field widths
	localparam int CMD_W  = 2;
	localparam int DLY_W  = 32;
	localparam int HDL_W  = 4;
	localparam int SEC_W  = 23;
	localparam int USEC_W = 20;
	localparam int ST_W   = 2;

	// Divide by 1000 through a reciprocal: x / 1000 == (x * DIV_RECIP) >> DIV_SHIFT
	// for every 32-bit x.
	localparam logic [DLY_W-1:0] MS_PER_SEC = 32'd1000;
	localparam int               RECIP_W    = 29;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 29'h10624DD3;
	localparam int               DIV_SHIFT  = 38;
	localparam int               PROD_W     = DLY_W + RECIP_W;
	localparam int               REM_W      = 10;
	localparam int               USQ_W      = 11;   // usecs_in / 1000 fits here
	localparam int               SECMS_W    = SEC_W + REM_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD  = 2'd0,
		CMD_DEL  = 2'd1,
		CMD_NEXT = 2'd2,
		CMD_UPD  = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_BADHANDLE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RES_OK,
		RES_ADD,
		RES_NEXT,
		RES_EMPTY,
		RES_FULL,
		RES_BAD
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_WALK,
		S_ADD_CUT,
		S_ADD_INS,
		S_DEL_WALK,
		S_DEL_DO,
		S_NX_MUL,
		S_NX_Q,
		S_NX_K,
		S_NX_RES,
		S_UPD_MUL,
		S_UPD_WR
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     ld;         // capture item, restart walk
		logic     walk_step;  // advance walk position, read ahead
		logic     sum_acc;    // add current difference to running sum
		logic     cut_wr;     // write cut difference of following entry
		logic     ins_wr;     // insert new timer
		logic     del_do;     // unlink timer
		logic     mul_head;   // multiply head delay by reciprocal
		logic     mul_upd;    // multiply update fields
		logic     div_q;      // take quotient
		logic     div_k;      // quotient times 1000
		logic     upd_wr;     // write updated delay
		logic     res_we;     // register result
		res_sel_t res_sel;
	} ctrl_t;

	// Status from datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic hdl_ok;
		logic walk_end;
		logic add_hit;
		logic del_hit;
	} stat_t;

endpackage

// ===== rtl/dtq_datapath.sv =====
// Datapath: delay memory, order list, walk position and sum, divide-by-1000 unit, result.
module dtq_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dtq_pkg::CMD_W-1:0]   cmd,
	input  logic [dtq_pkg::DLY_W-1:0]   delay_ms,
	input  logic [dtq_pkg::HDL_W-1:0]   handle_in,
	input  logic [dtq_pkg::SEC_W-1:0]   secs_in,
	input  logic [dtq_pkg::USEC_W-1:0]  usecs_in,
	input  dtq_pkg::ctrl_t              ctrl,
	output dtq_pkg::stat_t              stat,
	output logic                        done,
	output logic [dtq_pkg::ST_W-1:0]    status,
	output logic [dtq_pkg::HDL_W-1:0]   handle_out,
	output logic [dtq_pkg::SEC_W-1:0]   secs_out,
	output logic [dtq_pkg::USEC_W-1:0]  usecs_out
);
	import dtq_pkg::*;

	// Captured item
	cmd_t              cmd_q;
	logic [DLY_W-1:0]  ms_q;
	logic [HDL_W-1:0]  hdl_q;
	logic [SEC_W-1:0]  secs_q;
	logic [USEC_W-1:0] usecs_q;

	// Queue state
	logic [DLY_W-1:0]       mem [TIMER_SLOTS];
	logic [SLOT_W-1:0]      order_q [TIMER_SLOTS];
	logic [CNT_W-1:0]       cnt_q;
	logic [TIMER_SLOTS-1:0] used_q;

	// Walk and arithmetic
	logic [CNT_W-1:0]   pos_q;
	logic [DLY_W-1:0]   sum_q;
	logic [DLY_W-1:0]   rd_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SECMS_W-1:0] ps_q;
	logic [DLY_W-1:0]   d_q;
	logic [SEC_W-1:0]   q_q;
	logic [DLY_W-1:0]   qk_q;

	// Result
	logic [ST_W-1:0]   status_q;
	logic [HDL_W-1:0]  handle_q;
	logic [SEC_W-1:0]  secs_q2;
	logic [USEC_W-1:0] usecs_q2;
	logic              done_q;

	logic [SLOT_W-1:0]  pos_idx, pos_nx_idx, cur_slot, head_slot, hdl_idx, rd_addr;
	logic [SLOT_W-1:0]  free_slot;
	logic               free_any;
	logic [DLY_W-1:0]   walk_sum;
	logic               walk_end;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_addr;
	logic [DLY_W-1:0]   wr_data;
	logic [DLY_W-1:0]   mul_a;
	logic [SECMS_W:0]   upd_sum;
	logic [DLY_W-1:0]   upd_val;
	logic [DLY_W-1:0]   rem;
	logic [USEC_W-1:0]  rem_us;

	assign pos_idx    = pos_q[SLOT_W-1:0];
	assign pos_nx_idx = pos_idx + 1'b1;
	assign cur_slot   = order_q[pos_idx];
	assign head_slot  = order_q[0];
	assign hdl_idx    = SLOT_W'(hdl_q);
	assign rd_addr    = ctrl.walk_step ? order_q[pos_nx_idx] : cur_slot;
	assign walk_sum   = sum_q + rd_q;
	assign walk_end   = (pos_q >= cnt_q);

	// Lowest free slot
	always_comb begin
		free_slot = '0;
		free_any  = 1'b0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SLOT_W'(i);
				free_any  = 1'b1;
			end
		end
	end

	// Status to controller
	always_comb begin
		stat.cmd      = cmd_q;
		stat.full     = (cnt_q >= CNT_W'(TIMER_SLOTS)) || !free_any;
		stat.empty    = (cnt_q == '0);
		stat.hdl_ok   = (int'(hdl_q) < TIMER_SLOTS) && used_q[hdl_idx];
		stat.walk_end = walk_end;
		stat.add_hit  = (walk_sum > ms_q);
		stat.del_hit  = (cur_slot == hdl_idx);
	end

	// Update value: secs * 1000 + usecs / 1000, saturated to 32 bits
	assign upd_sum = (SECMS_W + 1)'(ps_q) + (SECMS_W + 1)'(prod_q[DIV_SHIFT +: USQ_W]);
	assign upd_val = (upd_sum[SECMS_W:DLY_W] != '0) ? '1 : upd_sum[DLY_W-1:0];

	// Memory write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_slot;
		wr_data = walk_sum - ms_q;
		if (ctrl.cut_wr && !walk_end) begin
			wr_en = 1'b1;
		end else if (ctrl.ins_wr) begin
			wr_en   = 1'b1;
			wr_addr = free_slot;
			wr_data = ms_q - sum_q;
		end else if (ctrl.upd_wr) begin
			wr_en   = 1'b1;
			wr_addr = hdl_idx;
			wr_data = upd_val;
		end
	end

	// Delay memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Item capture and walk registers
	always_ff @(posedge clk) begin
		if (ctrl.ld) begin
			cmd_q   <= cmd_t'(cmd);
			ms_q    <= delay_ms;
			hdl_q   <= handle_in;
			secs_q  <= secs_in;
			usecs_q <= usecs_in;
			pos_q   <= '0;
			sum_q   <= '0;
		end else begin
			if (ctrl.walk_step) begin
				pos_q <= pos_q + 1'b1;
			end
			if (ctrl.sum_acc) begin
				sum_q <= walk_sum;
			end
		end
	end

	// Order list shifts
	always_ff @(posedge clk) begin
		if (ctrl.ins_wr) begin
			if (pos_q == '0) begin
				order_q[0] <= free_slot;
			end
			for (int i = 1; i < TIMER_SLOTS; i++) begin
				if (CNT_W'(i) == pos_q) begin
					order_q[i] <= free_slot;
				end else if (CNT_W'(i) > pos_q && CNT_W'(i) <= cnt_q) begin
					order_q[i] <= order_q[i-1];
				end
			end
		end else if (ctrl.del_do) begin
			for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
				if (CNT_W'(i) >= pos_q && CNT_W'(i + 1) < cnt_q) begin
					order_q[i] <= order_q[i+1];
				end
			end
		end
	end

	// Count and busy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			used_q <= '0;
		end else if (ctrl.ins_wr) begin
			cnt_q             <= cnt_q + 1'b1;
			used_q[free_slot] <= 1'b1;
		end else if (ctrl.del_do) begin
			if (!walk_end) begin
				cnt_q <= cnt_q - 1'b1;
			end
			used_q[hdl_idx] <= 1'b0;
		end
	end

	// Shared reciprocal multiplier and constant multiplies
	assign mul_a = ctrl.mul_upd ? DLY_W'(usecs_q) : rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_head || ctrl.mul_upd) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(DIV_RECIP);
		end
		if (ctrl.mul_head) begin
			d_q <= rd_q;
		end
		if (ctrl.mul_upd) begin
			ps_q <= SECMS_W'(secs_q) * SECMS_W'(MS_PER_SEC);
		end
		if (ctrl.div_q) begin
			q_q <= prod_q[DIV_SHIFT +: SEC_W];
		end
		if (ctrl.div_k) begin
			qk_q <= DLY_W'(q_q) * MS_PER_SEC;
		end
	end

	// Remainder is below 1000
	assign rem    = d_q - qk_q;
	assign rem_us = USEC_W'(rem[REM_W-1:0]) * USEC_W'(MS_PER_SEC);

	// Result register
	always_ff @(posedge clk) begin
		if (ctrl.res_we) begin
			handle_q <= '0;
			secs_q2  <= '0;
			usecs_q2 <= '0;
			unique case (ctrl.res_sel)
				RES_OK: begin
					status_q <= ST_OK;
				end
				RES_ADD: begin
					status_q <= ST_OK;
					handle_q <= HDL_W'(free_slot);
				end
				RES_NEXT: begin
					status_q <= ST_OK;
					handle_q <= HDL_W'(head_slot);
					secs_q2  <= q_q;
					usecs_q2 <= rem_us;
				end
				RES_EMPTY: begin
					status_q <= ST_EMPTY;
				end
				RES_FULL: begin
					status_q <= ST_FULL;
				end
				RES_BAD: begin
					status_q <= ST_BADHANDLE;
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.res_we;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign handle_out = handle_q;
	assign secs_out   = secs_q2;
	assign usecs_out  = usecs_q2;

endmodule

// ===== rtl/dtq_ctrl.sv =====
// Controller: command sequencing for add, delete, get next and update.
module dtq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dtq_pkg::stat_t stat,
	output dtq_pkg::ctrl_t ctrl,
	output logic           busy
);
	import dtq_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		ctrl.res_sel = RES_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.ld = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_ADD: begin
						if (stat.full) begin
							ctrl.res_we  = 1'b1;
							ctrl.res_sel = RES_FULL;
							state_d      = S_IDLE;
						end else begin
							state_d = S_ADD_WALK;
						end
					end
					CMD_DEL: begin
						if (!stat.hdl_ok) begin
							ctrl.res_we  = 1'b1;
							ctrl.res_sel = RES_BAD;
							state_d      = S_IDLE;
						end else begin
							state_d = S_DEL_WALK;
						end
					end
					CMD_NEXT: begin
						if (stat.empty) begin
							ctrl.res_we  = 1'b1;
							ctrl.res_sel = RES_EMPTY;
							state_d      = S_IDLE;
						end else begin
							state_d = S_NX_MUL;
						end
					end
					CMD_UPD: begin
						if (!stat.hdl_ok) begin
							ctrl.res_we  = 1'b1;
							ctrl.res_sel = RES_BAD;
							state_d      = S_IDLE;
						end else begin
							state_d = S_UPD_MUL;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			// One stored difference per cycle until the sum passes the new delay or the list ends
			S_ADD_WALK: begin
				if (stat.walk_end || stat.add_hit) begin
					state_d = S_ADD_CUT;
				end else begin
					ctrl.walk_step = 1'b1;
					ctrl.sum_acc   = 1'b1;
				end
			end
			S_ADD_CUT: begin
				ctrl.cut_wr = 1'b1;
				state_d     = S_ADD_INS;
			end
			S_ADD_INS: begin
				ctrl.ins_wr  = 1'b1;
				ctrl.res_we  = 1'b1;
				ctrl.res_sel = RES_ADD;
				state_d      = S_IDLE;
			end
			S_DEL_WALK: begin
				if (stat.walk_end || stat.del_hit) begin
					state_d = S_DEL_DO;
				end else begin
					ctrl.walk_step = 1'b1;
				end
			end
			S_DEL_DO: begin
				ctrl.del_do  = 1'b1;
				ctrl.res_we  = 1'b1;
				ctrl.res_sel = RES_OK;
				state_d      = S_IDLE;
			end
			S_NX_MUL: begin
				ctrl.mul_head = 1'b1;
				state_d       = S_NX_Q;
			end
			S_NX_Q: begin
				ctrl.div_q = 1'b1;
				state_d    = S_NX_K;
			end
			S_NX_K: begin
				ctrl.div_k = 1'b1;
				state_d    = S_NX_RES;
			end
			S_NX_RES: begin
				ctrl.res_we  = 1'b1;
				ctrl.res_sel = RES_NEXT;
				state_d      = S_IDLE;
			end
			S_UPD_MUL: begin
				ctrl.mul_upd = 1'b1;
				state_d      = S_UPD_WR;
			end
			S_UPD_WR: begin
				ctrl.upd_wr  = 1'b1;
				ctrl.res_we  = 1'b1;
				ctrl.res_sel = RES_OK;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/delta_timer_queue.sv =====
// Delta timer queue: one command at a time, taken when start is high and busy is low. The
// result appears in the cycle in which busy falls, for exactly one cycle with done high; it
// cannot be held off, so capture it then. Error results (full, empty, bad handle) are decided
// in the decode step. Add walks the stored differences through the single read port of the
// delay memory, one entry per cycle, past the queued timers ahead of the new one. Delete scans
// the order list one position per cycle until it reaches the timer.
module delta_timer_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [dtq_pkg::CMD_W-1:0]   cmd,
	input  logic [dtq_pkg::DLY_W-1:0]   delay_ms,
	input  logic [dtq_pkg::HDL_W-1:0]   handle_in,
	input  logic [dtq_pkg::SEC_W-1:0]   secs_in,
	input  logic [dtq_pkg::USEC_W-1:0]  usecs_in,
	output logic                        done,
	output logic [dtq_pkg::ST_W-1:0]    status,
	output logic [dtq_pkg::HDL_W-1:0]   handle_out,
	output logic [dtq_pkg::SEC_W-1:0]   secs_out,
	output logic [dtq_pkg::USEC_W-1:0]  usecs_out
);
	import dtq_pkg::*;
	`include "delta_timer_queue_assert.svh"

	ctrl_t ctrl;
	stat_t stat;

	// Controller
	dtq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Datapath
	dtq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.delay_ms   (delay_ms),
		.handle_in  (handle_in),
		.secs_in    (secs_in),
		.usecs_in   (usecs_in),
		.ctrl       (ctrl),
		.stat       (stat),
		.done       (done),
		.status     (status),
		.handle_out (handle_out),
		.secs_out   (secs_out),
		.usecs_out  (usecs_out)
	);

	// Checks
	`DTQ_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "item taken but busy low")
	`DTQ_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`DTQ_ASSERT_SAME(a_err_fields_zero, done && (status != ST_OK), (handle_out == '0) && (secs_out == '0) && (usecs_out == '0), "error result with nonzero fields")
	`DTQ_ASSERT_SAME(a_ins_room, ctrl.ins_wr, !stat.full, "insert into full queue")

endmodule

// ===== bench/tb_delta_timer_queue.sv =====
// Self-checking testbench for the delta timer queue: directed and random commands, checked replies.
module tb_delta_timer_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import dtq_pkg::*;

	localparam logic [SEC_W-1:0]  SECS_TOP   = 23'd4294967;
	localparam logic [USEC_W-1:0] USECS_TOP  = 20'd999999;
	localparam int                RAND_ITEMS = 550;
	localparam int                STALL_MAX  = 4000;

	// One reply of the block
	typedef struct packed {
		status_t           st;
		logic [HDL_W-1:0]  hdl;
		logic [SEC_W-1:0]  sec;
		logic [USEC_W-1:0] usec;
	} timer_reply_t;

	// Tracks the timer list and holds the replies still to come
	class timer_queue_tracker;
		logic [DLY_W-1:0]  diff_ms [TIMER_SLOTS];
		logic [SLOT_W-1:0] queue_order [TIMER_SLOTS];
		bit                slot_taken [TIMER_SLOTS];
		int unsigned       queued;
		timer_reply_t      pending_replies [$];
		int                mismatches;

		function new();
			foreach (diff_ms[i]) begin
				diff_ms[i]     = '0;
				queue_order[i] = '0;
				slot_taken[i]  = 1'b0;
			end
			queued     = 0;
			mismatches = 0;
		endfunction

		// Absolute delay at the end of the first upto entries (wraps at 32 bits)
		function logic [DLY_W-1:0] running_sum(int unsigned upto);
			logic [DLY_W-1:0] acc;
			acc = '0;
			for (int unsigned p = 0; p < upto && p < queued; p++)
				acc = acc + diff_ms[queue_order[p]];
			return acc;
		endfunction

		function logic [HDL_W-1:0] any_taken_slot();
			int taken [$];
			foreach (slot_taken[i])
				if (slot_taken[i])
					taken.push_back(i);
			if (taken.size() == 0)
				return HDL_W'($urandom_range(0, TIMER_SLOTS - 1));
			return HDL_W'(taken[$urandom_range(0, taken.size() - 1)]);
		endfunction

		// Insert a timer where the running sum first passes the new delay
		function timer_reply_t add_timer(logic [DLY_W-1:0] ms);
			timer_reply_t     r;
			logic [DLY_W-1:0] acc, probe;
			int unsigned      pos, slot;
			r = '{ST_OK, '0, '0, '0};
			if (queued >= TIMER_SLOTS) begin
				r.st = ST_FULL;
				return r;
			end
			acc = '0;
			for (pos = 0; pos < queued; pos++) begin
				probe = acc + diff_ms[queue_order[pos]];
				if (probe > ms)
					break;
				acc = probe;
			end
			for (slot = 0; slot < TIMER_SLOTS; slot++)
				if (!slot_taken[slot])
					break;
			if (slot >= TIMER_SLOTS) begin
				r.st = ST_FULL;
				return r;
			end
			// following entry keeps its absolute delay
			if (pos < queued)
				diff_ms[queue_order[pos]] = acc + diff_ms[queue_order[pos]] - ms;
			for (int unsigned i = queued; i > pos; i--)
				queue_order[i] = queue_order[i - 1];
			queue_order[pos] = SLOT_W'(slot);
			diff_ms[slot]    = ms - acc;
			slot_taken[slot] = 1'b1;
			queued++;
			r.hdl = HDL_W'(slot);
			return r;
		endfunction

		// Unlink a timer; the one behind it keeps its stored difference
		function timer_reply_t drop_timer(logic [HDL_W-1:0] h);
			timer_reply_t r;
			int unsigned  pos;
			r = '{ST_OK, '0, '0, '0};
			if (!slot_taken[h]) begin
				r.st = ST_BADHANDLE;
				return r;
			end
			for (pos = 0; pos < queued; pos++)
				if (queue_order[pos] == h)
					break;
			if (pos < queued) begin
				for (int unsigned i = pos; i + 1 < queued; i++)
					queue_order[i] = queue_order[i + 1];
				queued--;
			end
			slot_taken[h] = 1'b0;
			return r;
		endfunction

		function timer_reply_t head_timer();
			timer_reply_t     r;
			logic [DLY_W-1:0] d;
			r = '{ST_OK, '0, '0, '0};
			if (queued == 0) begin
				r.st = ST_EMPTY;
				return r;
			end
			d      = diff_ms[queue_order[0]];
			r.hdl  = queue_order[0];
			r.sec  = SEC_W'(d / MS_PER_SEC);
			r.usec = USEC_W'((d % MS_PER_SEC) * MS_PER_SEC);
			return r;
		endfunction

		// New delay from seconds and microseconds, clipped to 32 bits
		function timer_reply_t retime_timer(logic [HDL_W-1:0] h, logic [SEC_W-1:0] s,
				logic [USEC_W-1:0] us);
			timer_reply_t r;
			logic [63:0]  v;
			r = '{ST_OK, '0, '0, '0};
			if (!slot_taken[h]) begin
				r.st = ST_BADHANDLE;
				return r;
			end
			v = 64'(s) * 64'd1000 + 64'(us) / 64'd1000;
			if (v > 64'hFFFF_FFFF)
				v = 64'hFFFF_FFFF;
			diff_ms[h] = v[DLY_W-1:0];
			return r;
		endfunction

		function void note_command(cmd_t c, logic [DLY_W-1:0] ms, logic [HDL_W-1:0] h,
				logic [SEC_W-1:0] s, logic [USEC_W-1:0] us);
			case (c)
				CMD_ADD:  pending_replies.push_back(add_timer(ms));
				CMD_DEL:  pending_replies.push_back(drop_timer(h));
				CMD_NEXT: pending_replies.push_back(head_timer());
				default:  pending_replies.push_back(retime_timer(h, s, us));
			endcase
		endfunction

		function void check_reply(timer_reply_t got);
			timer_reply_t want;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply with no command pending: status %0d handle %0d secs %0d usecs %0d",
						got.st, got.hdl, got.sec, got.usec);
				return;
			end
			want = pending_replies.pop_front();
			if (got.st !== want.st || got.hdl !== want.hdl || got.sec !== want.sec ||
					got.usec !== want.usec) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply mismatch at %0t: expected status %0d handle %0d secs %0d usecs %0d, got status %0d handle %0d secs %0d usecs %0d",
						$realtime, want.st, want.hdl, want.sec, want.usec,
						got.st, got.hdl, got.sec, got.usec);
			end
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  cmd;
	logic [DLY_W-1:0]  delay_ms;
	logic [HDL_W-1:0]  handle_in;
	logic [SEC_W-1:0]  secs_in;
	logic [USEC_W-1:0] usecs_in;
	logic              done;
	logic [ST_W-1:0]   status;
	logic [HDL_W-1:0]  handle_out;
	logic [SEC_W-1:0]  secs_out;
	logic [USEC_W-1:0] usecs_out;

	timer_queue_tracker sb = new();
	bit                 steady;
	int                 stall_cycles;

	delta_timer_queue i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.delay_ms   (delay_ms),
		.handle_in  (handle_in),
		.secs_in    (secs_in),
		.usecs_in   (usecs_in),
		.done       (done),
		.status     (status),
		.handle_out (handle_out),
		.secs_out   (secs_out),
		.usecs_out  (usecs_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Replies are checked at the edge that ends their cycle
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_reply('{status_t'(status), handle_out, secs_out, usecs_out});
	end

	// Watchdog: cycles with neither a command taken nor a reply
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Drive one command at the falling edge, hold it until taken
	task automatic send_item(input cmd_t c, input logic [DLY_W-1:0] ms = '0,
			input logic [HDL_W-1:0] h = '0, input logic [SEC_W-1:0] s = '0,
			input logic [USEC_W-1:0] us = '0);
		int gap;
		gap = 0;
		if (!steady) begin
			while ($urandom_range(0, 99) < 31)
				gap++;
			if ($urandom_range(0, 39) == 0)
				gap += $urandom_range(5, 30);
		end
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd       = c;
		delay_ms  = ms;
		handle_in = h;
		secs_in   = s;
		usecs_in  = us;
		start     = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(c, ms, h, s, us);
	endtask

	// Delays: small, wide, on and next to running-sum boundaries, extremes
	function automatic logic [DLY_W-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return DLY_W'($urandom_range(0, 5000));
			4, 5:       return DLY_W'($urandom);
			6:          return sb.running_sum($urandom_range(0, sb.queued));
			7:          return sb.running_sum($urandom_range(1, sb.queued + 1)) + 1;
			8:          return 32'hFFFF_FFFF - DLY_W'($urandom_range(0, 3));
			default:    return DLY_W'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [SEC_W-1:0] pick_secs();
		case ($urandom_range(0, 5))
			0, 1:    return SEC_W'($urandom_range(0, 20));
			2, 3:    return SEC_W'($urandom_range(0, SECS_TOP));
			4:       return SECS_TOP;
			default: return SEC_W'($urandom_range(SECS_TOP - 5000, SECS_TOP));
		endcase
	endfunction

	function automatic logic [USEC_W-1:0] pick_usecs();
		case ($urandom_range(0, 5))
			0:       return USECS_TOP;
			1:       return USEC_W'($urandom_range(0, 999));
			default: return USEC_W'($urandom_range(0, USECS_TOP));
		endcase
	endfunction

	initial begin
		cmd_t c;
		bit   filling;
		int   pick;

		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = CMD_ADD;
		delay_ms  = '0;
		handle_in = '0;
		secs_in   = '0;
		usecs_in  = '0;
		steady    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty queue, free handles, boundary delays, saturating update
		send_item(CMD_NEXT);
		send_item(CMD_DEL, '0, 4'd0);
		send_item(CMD_UPD, '0, 4'd15, SECS_TOP, USECS_TOP);
		send_item(CMD_ADD, 32'd0);
		send_item(CMD_ADD, 32'hFFFF_FFFF);
		send_item(CMD_ADD, 32'd1000);
		send_item(CMD_ADD, 32'd500);
		send_item(CMD_NEXT);
		send_item(CMD_UPD, '0, 4'd0, 23'd1, USECS_TOP);
		send_item(CMD_UPD, '0, 4'd3, SECS_TOP, USECS_TOP);
		send_item(CMD_NEXT);
		send_item(CMD_DEL, '0, 4'd0);
		send_item(CMD_NEXT);
		// fill every slot, then one add too many
		while (sb.queued < TIMER_SLOTS)
			send_item(CMD_ADD, DLY_W'($urandom));
		send_item(CMD_ADD, 32'd7);
		send_item(CMD_DEL, '0, 4'd7);
		send_item(CMD_UPD, '0, 4'd7, 23'd2, 20'd5);
		send_item(CMD_NEXT);

		// Random: the queue swings between filling and draining
		filling = 1'b1;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			steady = (n >= 200 && n < 330);
			if (sb.queued == 0)
				filling = 1'b1;
			else if (sb.queued == TIMER_SLOTS && $urandom_range(0, 2) == 0)
				filling = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < (filling ? 45 : 15))
				c = CMD_ADD;
			else if (pick < 60)
				c = CMD_DEL;
			else if (pick < 80)
				c = CMD_NEXT;
			else
				c = CMD_UPD;
			send_item(c, pick_delay(),
				($urandom_range(0, 99) < 85) ? sb.any_taken_slot()
					: HDL_W'($urandom_range(0, TIMER_SLOTS - 1)),
				pick_secs(), pick_usecs());
		end
		@(negedge clk);
		start = 1'b0;

		// Drain outstanding replies, then allow for stray ones
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
